// File: design/cru_pkg.sv
package cru_pkg;

    localparam int MAX_N     = 32;
    localparam int IDX_W     = $clog2(MAX_N);
    localparam int ORD_W     = IDX_W + 1;
    localparam int FA_W      = $clog2(MAX_N * MAX_N);
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 2;
    localparam int ST_W      = 2;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    // Rotation coefficients span [-1.0, 1.0] in Q16 and need 18 signed bits.
    localparam int CO_W = 18;

    // Divider: dividend magnitude bits and signed quotient width.
    localparam int DIV_NW = 50;
    localparam int DIV_QW = DIV_NW + 1;
    localparam int DEN_W  = DATA_W + 1;

    localparam int SQ_W     = 64;
    localparam int SQ_STEPS = SQ_W / 2;
    localparam int ROOT_W   = SQ_W / 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_VECTOR = 2'd2
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_DOMAIN = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE   = 1'd0,
        REG_LAYOUT = 1'd1
    } reg_idx_t;

    typedef struct packed {
        logic                     start;
        logic signed [63:0]       num;
        logic signed [DEN_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DIV_QW-1:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] radicand;
    } sq_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sq_rsp_t;

endpackage

// File: design/cru_if.sv
interface cru_in_if;
    logic                              valid;
    logic                              ready;
    logic [cru_pkg::CMD_W-1:0]         cmd;
    logic [cru_pkg::IDX_W-1:0]         row;
    logic [cru_pkg::IDX_W-1:0]         col;
    logic signed [cru_pkg::DATA_W-1:0] value;
    logic                              downdate;
    logic                              element_last;

    modport source (output valid, cmd, row, col, value, downdate, element_last,
                    input ready);
    modport sink   (input valid, cmd, row, col, value, downdate, element_last,
                    output ready);
endinterface

interface cru_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [cru_pkg::DATA_W-1:0] read_value;
    logic [cru_pkg::ST_W-1:0]          status;

    modport source (output valid, read_value, status, input ready);
    modport sink   (input valid, read_value, status, output ready);
endinterface

interface cru_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [cru_pkg::CFG_IDX_W-1:0] index;
    logic [cru_pkg::CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/cru_ram.sv
module cru_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/cru_sqrt.sv
module cru_sqrt (
    input  logic             clk,
    input  logic             rst_n,
    input  cru_pkg::sq_req_t req,
    output cru_pkg::sq_rsp_t rsp
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [$clog2(cru_pkg::SQ_STEPS)-1:0] cnt_reg;
    logic [cru_pkg::SQ_W-1:0]         v_reg;
    logic [cru_pkg::SQ_W-1:0]         res_reg;
    logic [cru_pkg::SQ_W-1:0]         bit_reg;
    logic [cru_pkg::SQ_W-1:0]         trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ($clog2(cru_pkg::SQ_STEPS))'(cru_pkg::SQ_STEPS - 1);
                v_reg    <= req.radicand;
                res_reg  <= '0;
                bit_reg  <= {2'b01, {(cru_pkg::SQ_W - 2){1'b0}}};
            end
            else if (busy_reg)
            begin
                if (v_reg >= trial)
                begin
                    v_reg   <= v_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = res_reg[cru_pkg::ROOT_W-1:0];

endmodule

// File: design/cru_div.sv
module cru_div (
    input  logic              clk,
    input  logic              rst_n,
    input  cru_pkg::div_req_t req,
    output cru_pkg::div_rsp_t rsp
);

    localparam int CNT_W = $clog2(cru_pkg::DIV_NW);

    logic                            busy_reg;
    logic                            done_reg;
    logic                            neg_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic [cru_pkg::DIV_NW-1:0]      nm_reg;
    logic [cru_pkg::DIV_NW-1:0]      q_reg;
    logic [cru_pkg::DEN_W-1:0]       den_reg;
    logic [cru_pkg::DEN_W-1:0]       rem_reg;
    logic [cru_pkg::DEN_W:0]         trial;
    logic [cru_pkg::DEN_W:0]         diff;
    logic                            ge;
    logic [63:0]                     num_abs;
    logic [cru_pkg::DEN_W-1:0]       den_abs;
    logic [cru_pkg::DIV_QW-1:0]      q_ext;

    assign num_abs = req.num[63] ? 64'(-req.num) : 64'(req.num);
    assign den_abs = req.den[cru_pkg::DEN_W-1] ? cru_pkg::DEN_W'(-req.den)
                                               : cru_pkg::DEN_W'(req.den);
    assign trial   = {rem_reg, nm_reg[cru_pkg::DIV_NW-1]};
    assign ge      = trial >= {1'b0, den_reg};
    assign diff    = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(cru_pkg::DIV_NW - 1);
                neg_reg  <= req.num[63] ^ req.den[cru_pkg::DEN_W-1];
                nm_reg   <= num_abs[cru_pkg::DIV_NW-1:0];
                den_reg  <= den_abs;
                rem_reg  <= '0;
                q_reg    <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? diff[cru_pkg::DEN_W-1:0] : trial[cru_pkg::DEN_W-1:0];
                nm_reg  <= nm_reg << 1;
                q_reg   <= {q_reg[cru_pkg::DIV_NW-2:0], ge};
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign q_ext    = {1'b0, q_reg};
    assign rsp.done = done_reg;
    assign rsp.quo  = neg_reg ? -$signed(q_ext) : $signed(q_ext);

endmodule

// File: design/cholesky_rank1_update_downdate.sv
// Channel  | Direction | Payload                                        | Purpose
// request  | in        | cmd, row, col, value, downdate, element_last   | store access, vector
// result   | out       | read_value, status                             | one per request
// cfg      | in        | index, data                                    | size and layout
//
// A write, a read or a vector element that is not last runs no sweep.
// A last element runs a sweep: per column a wait on the square root,
// plus two divisions for an update or the division for t for a downdate;
// then per remaining row a rotation, with the divider again for a downdate.
// One result register: a new request is taken while it waits, and the block stalls
// only at the end of that request until the slot is free. Reset leaves both stores as is.
module cholesky_rank1_update_downdate (
    input  logic clk,
    input  logic rst_n,
    cru_in_if.sink    request,
    cru_out_if.source result,
    cru_cfg_if.sink   cfg
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_RDWAIT, S_COL_RD, S_COL_LD, S_MUL_D, S_MUL_X, S_MUL_T,
        S_R2, S_SQ_WAIT, S_MUL_CD, S_DIAG_WR, S_DIV_T, S_DIV_C, S_DIV_S, S_K_START,
        S_K_RD, S_K_LD, S_KM1, S_KM2, S_KM3, S_KM4, S_KM5, S_KDIV, S_K_NEXT,
        S_NEXT_COL, S_FINISH
    } state_t;

    localparam int IW = cru_pkg::IDX_W;
    localparam int OW = cru_pkg::ORD_W;
    localparam int FW = cru_pkg::FA_W;
    localparam int DW = cru_pkg::DATA_W;
    localparam int CW = cru_pkg::CO_W;

    state_t state_reg;

    logic [cru_pkg::CFG_W-1:0] size_reg;
    logic                      upper_reg;

    logic [cru_pkg::CMD_W-1:0] cmd_reg;
    logic [IW-1:0]             row_reg;
    logic [IW-1:0]             col_reg;
    logic signed [DW-1:0]      value_reg;
    logic                      down_reg;
    logic                      last_reg;

    logic signed [DW-1:0]      rd_val_reg;
    logic [cru_pkg::ST_W-1:0]  st_reg;
    logic                      res_valid_reg;
    logic signed [DW-1:0]      res_value_reg;
    logic [cru_pkg::ST_W-1:0]  res_status_reg;

    logic [IW-1:0]             j_reg;
    logic [IW-1:0]             k_reg;
    logic signed [DW-1:0]      d_reg;
    logic signed [DW-1:0]      x_reg;
    logic signed [DW-1:0]      l_reg;
    logic signed [DW-1:0]      xk_reg;
    logic [DW-1:0]             r_reg;
    logic signed [CW-1:0]      t_reg;
    logic signed [CW-1:0]      c_reg;
    logic signed [CW-1:0]      s_reg;
    logic signed [63:0]        p_reg;
    logic signed [63:0]        acc_reg;
    logic signed [63:0]        numl_reg;

    logic [OW-1:0]             n_w;
    logic                      accept;
    logic                      res_load;
    logic                      row_out;
    logic                      col_out;
    logic                      j_more;
    logic                      k_more;
    logic                      cmd_is_write;
    logic                      cmd_is_read;
    logic                      cmd_is_vector;

    logic                      f_we;
    logic [FW-1:0]             f_waddr;
    logic [DW-1:0]             f_wdata;
    logic [FW-1:0]             f_raddr;
    logic [DW-1:0]             f_rdata;
    logic                      v_we;
    logic [IW-1:0]             v_waddr;
    logic [DW-1:0]             v_wdata;
    logic [IW-1:0]             v_raddr;
    logic [DW-1:0]             v_rdata;
    logic signed [DW-1:0]      fq;
    logic signed [DW-1:0]      vq;

    logic signed [DW:0]        mul_a;
    logic signed [DW:0]        mul_b;
    logic signed [2*DW+1:0]    mul_full;
    logic signed [63:0]        mul_p;

    logic [63:0]               r2;
    logic                      r2_bad;
    logic signed [63:0]        quo64;
    logic                      t_bad;
    logic [FW-1:0]             diag_addr;
    logic [FW-1:0]             off_addr;

    cru_pkg::div_req_t div_req;
    cru_pkg::div_rsp_t div_rsp;
    cru_pkg::sq_req_t  sq_req;
    cru_pkg::sq_rsp_t  sq_rsp;

    function automatic logic [FW-1:0] faddr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        faddr = FW'(int'(r) * cru_pkg::MAX_N + int'(c));
    endfunction

    function automatic logic signed [DW-1:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
        begin
            sat32 = 32'sh7fffffff;
        end
        else if (v < -64'sd2147483648)
        begin
            sat32 = 32'sh80000000;
        end
        else
        begin
            sat32 = v[DW-1:0];
        end
    endfunction

    // Division by 2^16 that truncates toward zero.
    function automatic logic signed [63:0] tdiv16(input logic signed [63:0] v);
        logic signed [63:0] b;
        b = v[63] ? v + 64'sd65535 : v;
        tdiv16 = b >>> 16;
    endfunction

    function automatic logic signed [CW-1:0] clamp1(input logic signed [63:0] v);
        if (v > 64'sd65536)
        begin
            clamp1 = 18'sd65536;
        end
        else if (v < -64'sd65536)
        begin
            clamp1 = -18'sd65536;
        end
        else
        begin
            clamp1 = v[CW-1:0];
        end
    endfunction

    cru_ram #(.WIDTH(DW), .DEPTH(cru_pkg::MAX_N * cru_pkg::MAX_N)) u_factor (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    cru_ram #(.WIDTH(DW), .DEPTH(cru_pkg::MAX_N)) u_vector (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    cru_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    cru_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .rsp   (sq_rsp)
    );

    assign fq = f_rdata;
    assign vq = v_rdata;

    always_comb
    begin
        if (size_reg == '0)
        begin
            n_w = OW'(1);
        end
        else if (int'(size_reg) > cru_pkg::MAX_N)
        begin
            n_w = OW'(cru_pkg::MAX_N);
        end
        else
        begin
            n_w = OW'(size_reg);
        end
    end

    assign accept        = request.valid && request.ready;
    assign request.ready = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign res_load      = (state_reg == S_FINISH) && (!res_valid_reg || result.ready);

    assign result.valid      = res_valid_reg;
    assign result.read_value = res_value_reg;
    assign result.status     = res_status_reg;

    assign cmd_is_write  = (cmd_reg == cru_pkg::CMD_WRITE);
    assign cmd_is_read   = (cmd_reg == cru_pkg::CMD_READ);
    assign cmd_is_vector = (cmd_reg == cru_pkg::CMD_VECTOR);
    assign row_out       = OW'(row_reg) >= n_w;
    assign col_out       = OW'(col_reg) >= n_w;
    assign j_more        = (OW'(j_reg) + OW'(1)) < n_w;
    assign k_more        = (OW'(k_reg) + OW'(1)) < n_w;
    assign diag_addr     = faddr(j_reg, j_reg);
    assign off_addr      = upper_reg ? faddr(j_reg, k_reg) : faddr(k_reg, j_reg);

    assign mul_full = mul_a * mul_b;
    assign mul_p    = mul_full[63:0];

    // Update radicand is d^2 + x^2; downdate radicand is 1.0 - t^2 in Q32.
    assign r2     = down_reg ? (64'h1_0000_0000 - 64'(p_reg)) : 64'(acc_reg) + 64'(p_reg);
    assign r2_bad = down_reg ? (r2[63] || (r2 == '0)) : (r2 == '0);
    assign quo64  = 64'(div_rsp.quo);
    assign t_bad  = (quo64 >= 64'sd65536) || (quo64 <= -64'sd65536);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL_D:
            begin
                mul_a = d_reg[DW-1] ? -(DW+1)'(d_reg) : (DW+1)'(d_reg);
                mul_b = mul_a;
            end
            S_MUL_X:
            begin
                mul_a = x_reg[DW-1] ? -(DW+1)'(x_reg) : (DW+1)'(x_reg);
                mul_b = mul_a;
            end
            S_MUL_T:
            begin
                mul_a = (DW+1)'(t_reg);
                mul_b = (DW+1)'(t_reg);
            end
            S_MUL_CD:
            begin
                mul_a = $signed({1'b0, r_reg});
                mul_b = (DW+1)'(d_reg);
            end
            S_KM1:
            begin
                mul_a = (DW+1)'(c_reg);
                mul_b = (DW+1)'(l_reg);
            end
            S_KM2:
            begin
                mul_a = (DW+1)'(s_reg);
                mul_b = (DW+1)'(xk_reg);
            end
            S_KM3:
            begin
                mul_a = (DW+1)'(c_reg);
                mul_b = (DW+1)'(xk_reg);
            end
            S_KM4:
            begin
                mul_a = (DW+1)'(s_reg);
                mul_b = (DW+1)'(l_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        f_we     = 1'b0;
        f_waddr  = diag_addr;
        f_wdata  = '0;
        f_raddr  = faddr(row_reg, col_reg);
        v_we     = 1'b0;
        v_waddr  = k_reg;
        v_wdata  = '0;
        v_raddr  = j_reg;
        div_req  = '0;
        sq_req   = '0;
        case (state_reg)
            S_DECODE:
            begin
                f_waddr = faddr(row_reg, col_reg);
                f_wdata = value_reg;
                f_we    = cmd_is_write && !row_out && !col_out;
                v_waddr = row_reg;
                v_wdata = value_reg;
                v_we    = cmd_is_vector && !row_out;
            end
            S_COL_RD:
            begin
                f_raddr = diag_addr;
                v_raddr = j_reg;
            end
            S_COL_LD:
            begin
                div_req.start = down_reg && (fq != '0);
                div_req.num   = {{16{vq[DW-1]}}, vq, 16'h0};
                div_req.den   = (DW+1)'(fq);
            end
            S_R2:
            begin
                sq_req.start    = !r2_bad;
                sq_req.radicand = r2;
            end
            S_DIAG_WR:
            begin
                f_we          = 1'b1;
                f_waddr       = diag_addr;
                f_wdata       = down_reg ? sat32(tdiv16(p_reg)) : r_reg;
                div_req.start = !down_reg && (x_reg != '0);
                div_req.num   = {{16{d_reg[DW-1]}}, d_reg, 16'h0};
                div_req.den   = $signed({1'b0, r_reg});
            end
            S_DIV_C:
            begin
                div_req.start = div_rsp.done;
                div_req.num   = {{16{x_reg[DW-1]}}, x_reg, 16'h0};
                div_req.den   = $signed({1'b0, r_reg});
            end
            S_K_RD:
            begin
                f_raddr = off_addr;
                v_raddr = k_reg;
            end
            S_KM5:
            begin
                v_we          = 1'b1;
                v_waddr       = k_reg;
                v_wdata       = sat32(tdiv16(acc_reg - p_reg));
                f_we          = !down_reg;
                f_waddr       = off_addr;
                f_wdata       = sat32(tdiv16(numl_reg));
                div_req.start = down_reg;
                div_req.num   = numl_reg;
                div_req.den   = (DW+1)'(c_reg);
            end
            S_KDIV:
            begin
                f_we    = div_rsp.done;
                f_waddr = off_addr;
                f_wdata = sat32(quo64);
            end
            default:
            begin
                f_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            size_reg      <= cru_pkg::CFG_W'(cru_pkg::MAX_N);
            upper_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == cru_pkg::REG_SIZE)
                begin
                    size_reg <= cfg.data;
                end
                else if (cfg.index == cru_pkg::REG_LAYOUT)
                begin
                    upper_reg <= cfg.data[0];
                end
            end

            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.valid && result.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg    <= request.cmd;
                        row_reg    <= request.row;
                        col_reg    <= request.col;
                        value_reg  <= request.value;
                        down_reg   <= request.downdate;
                        last_reg   <= request.element_last;
                        rd_val_reg <= '0;
                        st_reg     <= cru_pkg::ST_OK;
                        state_reg  <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    state_reg <= S_FINISH;
                    if ((cmd_is_write || cmd_is_read) && (row_out || col_out))
                    begin
                        st_reg <= cru_pkg::ST_RANGE;
                    end
                    else if (cmd_is_vector && row_out)
                    begin
                        st_reg <= cru_pkg::ST_RANGE;
                    end
                    else if (cmd_is_read)
                    begin
                        state_reg <= S_RDWAIT;
                    end
                    else if (cmd_is_vector && last_reg)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_COL_RD;
                    end
                end
                S_RDWAIT:
                begin
                    rd_val_reg <= fq;
                    state_reg  <= S_FINISH;
                end
                S_COL_RD:
                begin
                    state_reg <= S_COL_LD;
                end
                S_COL_LD:
                begin
                    d_reg <= fq;
                    x_reg <= vq;
                    if (!down_reg)
                    begin
                        state_reg <= S_MUL_D;
                    end
                    else if (fq == '0)
                    begin
                        t_reg     <= '0;
                        state_reg <= S_MUL_T;
                    end
                    else
                    begin
                        state_reg <= S_DIV_T;
                    end
                end
                S_MUL_D:
                begin
                    p_reg     <= mul_p;
                    state_reg <= S_MUL_X;
                end
                S_MUL_X:
                begin
                    acc_reg   <= p_reg;
                    p_reg     <= mul_p;
                    state_reg <= S_R2;
                end
                S_DIV_T:
                begin
                    if (div_rsp.done)
                    begin
                        if (t_bad)
                        begin
                            st_reg    <= cru_pkg::ST_DOMAIN;
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            t_reg     <= quo64[CW-1:0];
                            state_reg <= S_MUL_T;
                        end
                    end
                end
                S_MUL_T:
                begin
                    p_reg     <= mul_p;
                    state_reg <= S_R2;
                end
                S_R2:
                begin
                    if (r2_bad)
                    begin
                        st_reg    <= cru_pkg::ST_DOMAIN;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_SQ_WAIT;
                    end
                end
                S_SQ_WAIT:
                begin
                    if (sq_rsp.done)
                    begin
                        if (down_reg)
                        begin
                            r_reg     <= sq_rsp.root;
                            state_reg <= S_MUL_CD;
                        end
                        else
                        begin
                            r_reg     <= sq_rsp.root[DW-1] ? 32'h7fffffff : sq_rsp.root;
                            state_reg <= S_DIAG_WR;
                        end
                    end
                end
                S_MUL_CD:
                begin
                    p_reg     <= mul_p;
                    state_reg <= S_DIAG_WR;
                end
                S_DIAG_WR:
                begin
                    if (x_reg == '0)
                    begin
                        state_reg <= S_NEXT_COL;
                    end
                    else if (down_reg)
                    begin
                        c_reg     <= r_reg[CW-1:0];
                        s_reg     <= t_reg;
                        state_reg <= S_K_START;
                    end
                    else
                    begin
                        state_reg <= S_DIV_C;
                    end
                end
                S_DIV_C:
                begin
                    if (div_rsp.done)
                    begin
                        c_reg     <= clamp1(quo64);
                        state_reg <= S_DIV_S;
                    end
                end
                S_DIV_S:
                begin
                    if (div_rsp.done)
                    begin
                        s_reg     <= clamp1(quo64);
                        state_reg <= S_K_START;
                    end
                end
                S_K_START:
                begin
                    if (j_more)
                    begin
                        k_reg     <= j_reg + 1'b1;
                        state_reg <= S_K_RD;
                    end
                    else
                    begin
                        state_reg <= S_NEXT_COL;
                    end
                end
                S_K_RD:
                begin
                    state_reg <= S_K_LD;
                end
                S_K_LD:
                begin
                    l_reg     <= fq;
                    xk_reg    <= vq;
                    state_reg <= S_KM1;
                end
                S_KM1:
                begin
                    p_reg     <= mul_p;
                    state_reg <= S_KM2;
                end
                S_KM2:
                begin
                    acc_reg   <= down_reg ? {{16{l_reg[DW-1]}}, l_reg, 16'h0} : p_reg;
                    p_reg     <= mul_p;
                    state_reg <= S_KM3;
                end
                S_KM3:
                begin
                    numl_reg  <= down_reg ? acc_reg - p_reg : acc_reg + p_reg;
                    p_reg     <= mul_p;
                    state_reg <= S_KM4;
                end
                S_KM4:
                begin
                    acc_reg   <= p_reg;
                    p_reg     <= mul_p;
                    state_reg <= S_KM5;
                end
                S_KM5:
                begin
                    state_reg <= down_reg ? S_KDIV : S_K_NEXT;
                end
                S_KDIV:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_K_NEXT;
                    end
                end
                S_K_NEXT:
                begin
                    if (k_more)
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_K_RD;
                    end
                    else
                    begin
                        state_reg <= S_NEXT_COL;
                    end
                end
                S_NEXT_COL:
                begin
                    if (j_more)
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_COL_RD;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (res_load)
                    begin
                        res_value_reg  <= rd_val_reg;
                        res_status_reg <= st_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
